### rtl/fir_filter_macros.svh
// ----------------------------------------------------------------------------
// fir_filter_macros
// Assertion macros shared by the FIR filter RTL.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_MACROS_SVH
`define FIR_FILTER_MACROS_SVH

// Check that a condition implies another in the same cycle
`define FIR_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check that a condition implies another in the next cycle
`define FIR_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg
// Widths and defaults shared by the FIR filter modules.
// ----------------------------------------------------------------------------
package fir_pkg;

   // Sample and coefficient format, Q1.15
   localparam int DATA_W    = 16;
   localparam int COEF_W    = 16;
   localparam int PROD_W    = DATA_W + COEF_W;
   localparam int FRAC_BITS = 15;

   // Coefficient register file
   localparam int NUM_COEFS = 8;
   localparam int CSR_IDX_W = $clog2(NUM_COEFS);

   // Default tap count
   localparam int DEFAULT_NUM_TAPS = 8;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0] coef_type;

endpackage

### rtl/fir_dline.sv
// ----------------------------------------------------------------------------
// fir_dline
// Circular delay-line memory with one write port and one registered read
// port. Entries not written since reset read as zero.
// ----------------------------------------------------------------------------
module fir_dline
   import fir_pkg::*;
#(
   parameter int NUM_TAPS = DEFAULT_NUM_TAPS,
   localparam int TAP_W   = $clog2(NUM_TAPS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [TAP_W-1:0] wr_addr,
   input  sample_type       wr_data,
   input  logic             rd_en,
   input  logic [TAP_W-1:0] rd_addr,
   output sample_type       rd_data
);

   sample_type          mem [NUM_TAPS];
   logic [NUM_TAPS-1:0] valid_ff;
   sample_type          rd_data_ff;
   logic                rd_ok_ff;

   // Write the new sample
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Mark entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Read one entry, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_ok_ff   <= valid_ff[rd_addr];
      end
   end

   // Drop stale data of entries never written
   assign rd_data = rd_ok_ff ? rd_data_ff : '0;

endmodule

### rtl/fir_filter.sv
// ----------------------------------------------------------------------------
// fir_filter
// Direct-form FIR filter, Q1.15 samples and coefficients, exact accumulation,
// round-half-up by 15 bits and 16-bit saturation.
// ----------------------------------------------------------------------------
// A new request is accepted only once the previous sum has been loaded into
// the output register. The delay line sits in a memory with one read port,
// so one tap is read and multiplied per cycle, followed by the multiply and
// accumulate stages and the rounding logic. The finished result sits in an
// output register, so a new request is accepted while the previous result
// still waits for rsp_tready. Csr coefficient writes take effect from the
// next tap read, even within a run; the delay line reads as zero after reset.
module fir_filter
   import fir_pkg::*;
#(
   parameter int NUM_TAPS = DEFAULT_NUM_TAPS
) (
   input  logic                 clock,
   input  logic                 reset,
   // request: [15:0] sample_in
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,
   // response: [15:0] filtered_out
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,
   // coefficient writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [COEF_W-1:0]    csr_wdata
);

   localparam int TAP_W = $clog2(NUM_TAPS);
   localparam int ACC_W = PROD_W + $clog2(NUM_TAPS);
   localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(NUM_TAPS - 1);

   localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(2 ** (FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(2 ** (DATA_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] SAT_MIN  = -SAT_MAX - ACC_W'(1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [TAP_W-1:0]  wptr_ff, wptr_in;
   logic [TAP_W-1:0]  rptr_ff, rptr_in;
   logic [TAP_W-1:0]  tap_ff, tap_in;
   coef_type          coef_ff [NUM_COEFS];
   coef_type          coef_s1_ff;
   logic              s1_vld_ff, s1_last_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic              s2_vld_ff, s2_last_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic              acc_done_ff;
   logic              rsp_vld_ff;
   sample_type        rsp_data_ff;

   logic              req_acc;
   logic              rd_issue;
   logic              out_load;
   sample_type        dl_rd_data;
   logic signed [ACC_W-1:0] rnd_sum;
   logic signed [ACC_W-1:0] q_full;
   sample_type        sat_val;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rd_issue   = (state_ff == ST_RUN);
   assign out_load   = (state_ff == ST_DRAIN) && acc_done_ff
                       && (!rsp_vld_ff || rsp_tready);

   // Delay-line memory
   fir_dline #(
      .NUM_TAPS (NUM_TAPS)
   ) u_dline (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_acc),
      .wr_addr (wptr_ff),
      .wr_data (sample_type'(req_tdata)),
      .rd_en   (rd_issue),
      .rd_addr (rptr_ff),
      .rd_data (dl_rd_data)
   );

   // Hold coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_we) begin
         coef_ff[csr_addr] <= coef_type'(csr_wdata);
      end
   end

   // Sequence the tap reads
   always_comb begin
      state_in = state_ff;
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      tap_in   = tap_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_RUN;
               rptr_in  = wptr_ff;
               tap_in   = '0;
               wptr_in  = (wptr_ff == LAST_TAP) ? '0 : wptr_ff + TAP_W'(1);
            end
         end
         ST_RUN: begin
            rptr_in = (rptr_ff == '0) ? LAST_TAP : rptr_ff - TAP_W'(1);
            if (tap_ff == LAST_TAP) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + TAP_W'(1);
            end
         end
         ST_DRAIN: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         tap_ff   <= tap_in;
      end
   end

   // Fetch coefficient alongside the memory read
   always_ff @(posedge clock) begin
      if (rd_issue) begin
         coef_s1_ff <= coef_ff[CSR_IDX_W'(tap_ff)];
      end
   end

   // Advance stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s1_last_ff <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s2_last_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= rd_issue;
         s1_last_ff <= rd_issue && (tap_ff == LAST_TAP);
         s2_vld_ff  <= s1_vld_ff;
         s2_last_ff <= s1_vld_ff && s1_last_ff;
      end
   end

   // Multiply one tap
   always_ff @(posedge clock) begin
      prod_ff <= dl_rd_data * coef_s1_ff;
   end

   // Accumulate products, clear on a new request
   always_ff @(posedge clock) begin
      if (req_acc) begin
         acc_ff <= '0;
      end else if (s2_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_done_ff <= 1'b0;
      end else if (out_load) begin
         acc_done_ff <= 1'b0;
      end else if (s2_vld_ff && s2_last_ff) begin
         acc_done_ff <= 1'b1;
      end
   end

   // Round half up, shift and saturate
   assign rnd_sum = acc_ff + RND_BIAS;
   assign q_full  = rnd_sum >>> FRAC_BITS;

   always_comb begin
      priority if (q_full > SAT_MAX) begin
         sat_val = SAT_MAX[DATA_W-1:0];
      end else if (q_full < SAT_MIN) begin
         sat_val = SAT_MIN[DATA_W-1:0];
      end else begin
         sat_val = q_full[DATA_W-1:0];
      end
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= sat_val;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
`include "fir_filter_macros.svh"

   `FIR_ASSERT_NEXT(a_accept_starts_run, clock, reset, req_acc, (state_ff == ST_RUN) && (tap_ff == '0), "request did not start a tap run")
   `FIR_ASSERT_SAME(a_load_needs_sum, clock, reset, out_load, acc_done_ff && !s1_vld_ff && !s2_vld_ff, "response loaded before the sum was complete")
   `FIR_ASSERT_SAME(a_tap_in_range, clock, reset, 1'b1, tap_ff <= LAST_TAP, "tap counter beyond the last tap")
   `FIR_ASSERT_SAME(a_no_read_when_idle, clock, reset, state_ff == ST_IDLE, !s1_vld_ff && !s2_vld_ff && !acc_done_ff, "pipeline busy while idle")

endmodule
